[rtl/core/wdf_pkg.sv]
package wdf_pkg;

	localparam int WIN_LEN    = 24;
	localparam int TAPS       = 8;
	localparam int FULL_MODE0 = 20;
	localparam int FULL_MODE1 = 24;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int GROUP      = 4;
	localparam int NGROUPS    = WIN_LEN / GROUP;
	localparam int SUM_W      = PROD_W + 6;
	localparam int QUO_SHIFT  = 15;
	localparam int FILL_W     = 5;

	localparam int BLK_FULL [TAPS]    = '{417, 4233, 16655, 30465, 30465, 16655, 4233, 417};
	localparam int BLK_THREE_Q [TAPS] = '{313, 3175, 12491, 22849, 22849, 12491, 3175, 313};
	localparam int BLK_ONE_Q [TAPS]   = '{104, 1058, 4164, 7616, 7616, 4164, 1058, 104};

	typedef enum logic {
		MODE_TWO_WIN   = 1'b0,
		MODE_THREE_WIN = 1'b1
	} mode_t;

	// combined weight of one window position, oldest position first
	function automatic int tap_coef(input int sel, input int pos);
		int c;
		c = 0;
		if (sel == 0) begin
			if (pos >= 4 && pos < 4 + TAPS)
				c = c - BLK_FULL[pos - 4];
			if (pos >= 16 && pos < 16 + TAPS)
				c = c + BLK_FULL[pos - 16];
		end else begin
			if (pos < TAPS)
				c = c + BLK_THREE_Q[pos];
			if (pos >= 4 && pos < 4 + TAPS)
				c = c - BLK_FULL[pos - 4];
			if (pos >= 16 && pos < 16 + TAPS)
				c = c + BLK_ONE_Q[pos - 16];
		end
		return c;
	endfunction

endpackage

[rtl/core/windowed_difference_fir_filter_unit.sv]
// Blackman-windowed difference FIR over a 24-sample window. One sample word is
// taken every cycle while in_stall is low, and each gives one result word through
// a five-stage pipeline: window capture, 24 parallel constant-weight multiplier
// lanes, partial sums of four, final sum, then divide by 32768 (toward zero)
// and saturate. Stages hold independently, so bubbles close up under output
// stall and input is stalled only when every stage holds a word. mode must be
// written only while no word is in flight; the block does not enforce this.
module windowed_difference_fir_filter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  filtered,
	output logic                window_full
);

	localparam int WL = wdf_pkg::WIN_LEN;
	localparam int NG = wdf_pkg::NGROUPS;
	localparam int GS = wdf_pkg::GROUP;

	wdf_pkg::mode_t mode_q;

	logic signed [wdf_pkg::SAMPLE_W-1:0] win_q [WL-1];
	logic [wdf_pkg::FILL_W-1:0]          fill_q;
	logic [wdf_pkg::FILL_W-1:0]          fill_next;
	logic [wdf_pkg::FILL_W-1:0]          need;

	logic signed [wdf_pkg::SAMPLE_W-1:0] win_s1 [WL];
	wdf_pkg::mode_t                      mode_s1;
	logic                                full_s1, full_s2, full_s3, full_s4;
	logic signed [wdf_pkg::PROD_W-1:0]   prod_s2 [WL];
	logic signed [wdf_pkg::SUM_W-1:0]    part_s3 [NG];
	logic signed [wdf_pkg::SUM_W-1:0]    part_d [NG];
	logic signed [wdf_pkg::SUM_W-1:0]    sum_s4;
	logic signed [wdf_pkg::SUM_W-1:0]    sum_d;
	logic signed [wdf_pkg::SUM_W-1:0]    rnd_d;
	logic signed [wdf_pkg::SUM_W-wdf_pkg::QUO_SHIFT-1:0] quo_d;
	logic signed [15:0]                  sat_d;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic adv1, adv2, adv3, adv4, adv5;
	logic acc;

	assign adv5     = !vld_s5 || !out_stall;
	assign adv4     = !vld_s4 || adv5;
	assign adv3     = !vld_s3 || adv4;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_stall = !adv1;
	assign acc      = in_valid && adv1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wdf_pkg::MODE_TWO_WIN;
		end else if (cfg_we) begin
			mode_q <= wdf_pkg::mode_t'(cfg_wdata);
		end
	end

	assign fill_next = (fill_q < wdf_pkg::FILL_W'(WL)) ? fill_q + 1'b1 : fill_q;
	assign need = (mode_q == wdf_pkg::MODE_THREE_WIN) ? wdf_pkg::FILL_W'(wdf_pkg::FULL_MODE1)
	                                                  : wdf_pkg::FILL_W'(wdf_pkg::FULL_MODE0);

	// shift the window and capture it with the newest sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WL - 1; i++)
				win_q[i] <= '0;
			fill_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (adv1)
				vld_s1 <= in_valid;
			if (acc) begin
				for (int i = 0; i < WL - 2; i++)
					win_q[i] <= win_q[i + 1];
				win_q[WL - 2] <= sample;
				fill_q <= fill_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < WL - 1; i++)
				win_s1[i] <= win_q[i];
			win_s1[WL - 1] <= sample;
			mode_s1 <= mode_q;
			full_s1 <= (fill_next >= need);
		end
	end

	// one constant-weight multiplier per window position
	for (genvar k = 0; k < WL; k++) begin : g_lane
		localparam logic signed [wdf_pkg::COEF_W-1:0] C0 =
			wdf_pkg::COEF_W'(wdf_pkg::tap_coef(0, k));
		localparam logic signed [wdf_pkg::COEF_W-1:0] C1 =
			wdf_pkg::COEF_W'(wdf_pkg::tap_coef(1, k));
		logic signed [wdf_pkg::COEF_W-1:0] coef;

		assign coef = (mode_s1 == wdf_pkg::MODE_THREE_WIN) ? C1 : C0;

		always_ff @(posedge clk) begin
			if (vld_s1 && adv2)
				prod_s2[k] <= win_s1[k] * coef;
		end
	end

	for (genvar g = 0; g < NG; g++) begin : g_part
		always_comb begin
			part_d[g] = '0;
			for (int j = 0; j < GS; j++)
				part_d[g] = part_d[g] + wdf_pkg::SUM_W'(prod_s2[g * GS + j]);
		end
	end

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NG; g++)
			sum_d = sum_d + part_s3[g];
	end

	// divide by 32768 toward zero, then saturate
	assign rnd_d = sum_s4 + (sum_s4[wdf_pkg::SUM_W-1]
		? wdf_pkg::SUM_W'((1 << wdf_pkg::QUO_SHIFT) - 1) : wdf_pkg::SUM_W'(0));
	assign quo_d = rnd_d[wdf_pkg::SUM_W-1:wdf_pkg::QUO_SHIFT];

	always_comb begin
		if (quo_d > $signed(wdf_pkg::SUM_W'(32767)))
			sat_d = 16'sh7fff;
		else if (quo_d < -$signed(wdf_pkg::SUM_W'(32768)))
			sat_d = -16'sh8000;
		else
			sat_d = quo_d[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv2)
				vld_s2 <= vld_s1;
			if (adv3)
				vld_s3 <= vld_s2;
			if (adv4)
				vld_s4 <= vld_s3;
			if (adv5)
				vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && adv2)
			full_s2 <= full_s1;
		if (vld_s2 && adv3) begin
			for (int g = 0; g < NG; g++)
				part_s3[g] <= part_d[g];
			full_s3 <= full_s2;
		end
		if (vld_s3 && adv4) begin
			sum_s4 <= sum_d;
			full_s4 <= full_s3;
		end
		if (vld_s4 && adv5) begin
			filtered    <= sat_d;
			window_full <= full_s4;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= wdf_pkg::FILL_W'(WL))
		else $error("fill count beyond window length");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_stall))
		else $error("input stalled with a bubble in the pipeline");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && fill_q != wdf_pkg::FILL_W'(WL)) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count missed an accepted word");

endmodule

[tb/wdf_checker.sv]
`timescale 1ns / 1ps

module wdf_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] sample,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] filtered,
	input  logic               window_full,
	output int                 fail_count,
	output int                 words_pending,
	output int                 words_checked
);

	typedef struct packed {
		logic signed [15:0] filtered;
		logic               window_full;
	} fir_word_t;

	localparam longint BLACKMAN [8] = '{417, 4233, 16655, 30465, 30465, 16655, 4233, 417};
	localparam longint BLACKMAN_3Q [8] = '{313, 3175, 12491, 22849, 22849, 12491, 3175, 313};
	localparam longint BLACKMAN_1Q [8] = '{104, 1058, 4164, 7616, 7616, 4164, 1058, 104};

	wdf_pkg::mode_t     filter_mode;
	logic signed [15:0] history [23];
	logic signed [15:0] span [24];
	int                 samples_seen;
	fir_word_t          due_words [$];
	fir_word_t          want;

	function automatic fir_word_t fir_response(input logic signed [15:0] w [24],
			input wdf_pkg::mode_t m, input int seen);
		longint    acc;
		longint    quo;
		fir_word_t r;
		acc = 0;
		for (int i = 0; i < 8; i++) begin
			if (m == wdf_pkg::MODE_TWO_WIN)
				acc += BLACKMAN[i] * (longint'(w[16 + i]) - longint'(w[4 + i]));
			else
				acc += BLACKMAN_3Q[i] * longint'(w[i]) - BLACKMAN[i] * longint'(w[4 + i])
					+ BLACKMAN_1Q[i] * longint'(w[16 + i]);
		end
		quo = acc / 32768;
		if (quo > 32767)
			quo = 32767;
		if (quo < -32768)
			quo = -32768;
		r.filtered    = quo[15:0];
		r.window_full = (seen >= ((m == wdf_pkg::MODE_TWO_WIN) ? 20 : 24));
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch on result word %0d: %s", $time, words_checked, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 23; i++)
				history[i] = '0;
			samples_seen  = 0;
			filter_mode   = wdf_pkg::MODE_TWO_WIN;
			due_words.delete();
			fail_count    = 0;
			words_pending = 0;
			words_checked = 0;
		end else begin
			if (in_valid && !in_stall) begin
				for (int i = 0; i < 23; i++)
					span[i] = history[i];
				span[23] = sample;
				for (int i = 0; i < 23; i++)
					history[i] = span[i + 1];
				if (samples_seen < 24)
					samples_seen++;
				due_words.push_back(fir_response(span, filter_mode, samples_seen));
			end
			if (cfg_we)
				filter_mode = wdf_pkg::mode_t'(cfg_wdata);
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					report_mismatch($sformatf("unexpected word, filtered %0d window_full %0b",
						filtered, window_full));
				end else begin
					want = due_words.pop_front();
					if (filtered !== want.filtered)
						report_mismatch($sformatf("filtered %0d, expected %0d",
							filtered, want.filtered));
					if (window_full !== want.window_full)
						report_mismatch($sformatf("window_full %0b, expected %0b",
							window_full, want.window_full));
				end
				words_checked++;
			end
			words_pending = due_words.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int QUIET_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 345;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] sample;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] filtered;
	logic               window_full;

	int fail_count;
	int words_pending;
	int words_checked;
	int samples_sent;
	int mode_writes;
	int quiet_cycles;
	bit press_req;
	bit square_high;
	int square_left;

	windowed_difference_fir_filter_unit i_dut (.*);

	wdf_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// an accepted word on either channel resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no word moved for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int span_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (press_req) begin
				press_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				kind     = $urandom_range(0, 3);
				span_len = $urandom_range(10, 60);
				repeat (span_len) begin
					case (kind)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= $urandom_range(0, 1);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(negedge clk);
				end
			end
		end
	end

	function automatic logic signed [15:0] pick_sample(input int shape);
		case (shape)
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 400)) - 200);
			2: begin
				if (square_left == 0) begin
					square_high = !square_high;
					square_left = $urandom_range(4, 12);
				end
				square_left--;
				return square_high ? 16'sh7fff : 16'sh8000;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic drive_sample(input logic signed [15:0] s);
		in_valid <= 1'b1;
		sample   <= s;
		do
			@(posedge clk);
		while (in_stall);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_mode(input wdf_pkg::mode_t m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
		mode_writes++;
	endtask

	task automatic run_phase(input wdf_pkg::mode_t m, input int count);
		int burst_left;
		int shape;
		int gap;
		burst_left = 0;
		shape      = 0;
		wait_drained();
		write_mode(m);
		press_req = 1'b1;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 25);
				shape = $urandom_range(0, 3);
				gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0)
					idle_gap(gap);
			end
			drive_sample(pick_sample(shape));
			burst_left--;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		in_valid     = 1'b0;
		sample       = '0;
		press_req    = 1'b0;
		square_high  = 1'b0;
		square_left  = 0;
		samples_sent = 0;
		mode_writes  = 0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// partial window in both modes, then a full-scale step into saturation
		drive_sample(16'sh7fff);
		drive_sample(16'sh8000);
		drive_sample(-16'sd1);
		drive_sample(16'sd1);
		wait_drained();
		write_mode(wdf_pkg::MODE_THREE_WIN);
		repeat (8) drive_sample(16'sh8000);
		wait_drained();
		write_mode(wdf_pkg::MODE_TWO_WIN);
		repeat (4) drive_sample(16'sh0000);
		repeat (8) drive_sample(16'sh7fff);

		run_phase(wdf_pkg::MODE_THREE_WIN, PHASE_ITEMS);
		run_phase(wdf_pkg::MODE_TWO_WIN, PHASE_ITEMS);
		run_phase(wdf_pkg::MODE_THREE_WIN, PHASE_ITEMS);
		run_phase(wdf_pkg::MODE_TWO_WIN, PHASE_ITEMS);
		run_phase(wdf_pkg::MODE_THREE_WIN, PHASE_ITEMS);

		wait_drained();
		repeat (10) @(negedge clk);
		$display("Covered %0d samples across %0d mode writes: both filters, filling window, ",
			samples_sent, mode_writes);
		$display("saturating steps and long output hold-offs; %0d result words compared.",
			words_checked);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/wdf_pkg.sv
rtl/core/windowed_difference_fir_filter_unit.sv
tb/wdf_checker.sv
tb/tb.sv
